### design/lfu_pkg.sv
package lfu_pkg;

    // default sizes
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 64;
    localparam int DEF_COUNT_BITS = 32;

    // stream payload widths
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 8;
    localparam int SLOT_W      = 4;

    // command codes carried in tuser
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

endpackage

### design/lfu_ram.sv
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/lfu_cache_directory.sv
// lfu_cache_directory: fully associative directory of ENTRIES tags with a
// saturating use count per entry. A transaction on the slave side carries a
// command in tuser (lookup or insert) and a key in tdata. A lookup walks the
// filled slots from slot 0 up, one slot per cycle, and stops at the first
// tag match, bumping that slot's count. An insert into a table that is not
// full takes the next free slot; into a full table it walks all slots to
// find the lowest-index entry with the smallest count and overwrites it.
// Either insert path sets the count to one; duplicates are not checked.
// Tags and counts live in two single-port-write RAMs with registered reads,
// and the walk is the one compare unit stepping through them. The slave
// side is ready only while no operation is in progress, which is from the
// edge where the result is first offered on the master side on; a finished
// result waits in an output register, so the next transaction may be
// accepted before it is taken.
// No clearing pass: only filled slots are ever read.
module lfu_cache_directory #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [lfu_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // [63:0] key
    input  logic [lfu_pkg::IN_TUSER_W-1:0] s_axis_tuser,   // [0] command
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [lfu_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [0] hit, [4:1] slot,
                                                           // [5] replaced, [7:6] zero
);

    import lfu_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [FILL_W-1:0]     FULL_FILL = FILL_W'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]            r_state,   n_state;
    logic [FILL_W-1:0]     r_fill,    n_fill;
    logic                  r_cmd,     n_cmd;
    logic [KEY_BITS-1:0]   r_key,     n_key;
    logic [IDX_W-1:0]      r_last,    n_last;
    logic                  r_iss,     n_iss;
    logic [IDX_W-1:0]      r_addr,    n_addr;
    logic                  r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]      r_chk_idx, n_chk_idx;
    logic [COUNT_BITS-1:0] r_min,     n_min;
    logic [IDX_W-1:0]      r_slot,    n_slot;
    logic                  r_hit,     n_hit;
    logic                  r_repl,    n_repl;
    logic [COUNT_BITS-1:0] r_cnt_new, n_cnt_new;
    logic                  r_out_vld, n_out_vld;
    logic                  r_out_hit, n_out_hit;
    logic [SLOT_W-1:0]     r_out_slot, n_out_slot;
    logic                  r_out_repl, n_out_repl;

    logic                  in_fire;
    logic                  tag_we;
    logic                  cnt_we;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [KEY_BITS-1:0]   tag_rdata;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic                  tag_match;
    logic                  new_min;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // entry storage, both read at the walk address
    lfu_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_slot),
        .i_wdata (r_key),
        .i_raddr (r_addr),
        .o_rdata (tag_rdata)
    );

    lfu_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ENTRIES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_slot),
        .i_wdata (cnt_wdata),
        .i_raddr (r_addr),
        .o_rdata (cnt_rdata)
    );

    // the shared compare unit: tag equality on lookup, count ordering on insert
    assign tag_match = (tag_rdata == r_key);
    assign new_min   = (r_chk_idx == '0) || (cnt_rdata < r_min);

    assign tag_we    = (r_state == S_WRITE) && (r_cmd == CMD_INSERT);
    assign cnt_we    = (r_state == S_WRITE);
    assign cnt_wdata = (r_cmd == CMD_INSERT) ? CNT_ONE : r_cnt_new;

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_last     = r_last;
        n_iss      = r_iss;
        n_addr     = r_addr;
        n_chk_vld  = r_chk_vld;
        n_chk_idx  = r_chk_idx;
        n_min      = r_min;
        n_slot     = r_slot;
        n_hit      = r_hit;
        n_repl     = r_repl;
        n_cnt_new  = r_cnt_new;
        n_out_hit  = r_out_hit;
        n_out_slot = r_out_slot;
        n_out_repl = r_out_repl;
        n_out_vld  = r_out_vld && !m_axis_tready;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd     = s_axis_tuser[0];
                    n_key     = s_axis_tdata[KEY_BITS-1:0];
                    n_hit     = 1'b0;
                    n_repl    = 1'b0;
                    n_slot    = '0;
                    n_addr    = '0;
                    n_iss     = 1'b1;
                    n_chk_vld = 1'b0;
                    if (s_axis_tuser[0] == CMD_LOOKUP) begin
                        n_last = IDX_W'(r_fill - FILL_W'(1));
                        // empty table: nothing to walk
                        n_state = (r_fill == '0) ? S_DONE : S_SCAN;
                    end else if (r_fill != FULL_FILL) begin
                        n_slot  = IDX_W'(r_fill);
                        n_state = S_WRITE;
                    end else begin
                        n_last  = LAST_IDX;
                        n_repl  = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue stage: address the next slot
                if (r_iss) begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_addr;
                    if (r_addr == r_last) begin
                        n_iss = 1'b0;
                    end else begin
                        n_addr = r_addr + IDX_W'(1);
                    end
                end else begin
                    n_chk_vld = 1'b0;
                end
                // compare stage: data from the slot issued last cycle
                if (r_chk_vld) begin
                    if (r_cmd == CMD_LOOKUP) begin
                        if (tag_match) begin
                            n_hit     = 1'b1;
                            n_slot    = r_chk_idx;
                            n_cnt_new = (cnt_rdata == CNT_MAX) ? CNT_MAX
                                                               : cnt_rdata + CNT_ONE;
                            n_iss     = 1'b0;
                            n_chk_vld = 1'b0;
                            n_state   = S_WRITE;
                        end else if (r_chk_idx == r_last) begin
                            n_chk_vld = 1'b0;
                            n_state   = S_DONE;
                        end
                    end else begin
                        if (new_min) begin
                            n_min  = cnt_rdata;
                            n_slot = r_chk_idx;
                        end
                        if (r_chk_idx == r_last) begin
                            n_chk_vld = 1'b0;
                            n_state   = S_WRITE;
                        end
                    end
                end
            end
            S_WRITE: begin
                if ((r_cmd == CMD_INSERT) && !r_repl) begin
                    n_fill = r_fill + FILL_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_hit  = r_hit;
                    n_out_slot = SLOT_W'(r_slot);
                    n_out_repl = r_repl;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_iss     <= 1'b0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_iss     <= n_iss;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_last     <= n_last;
        r_addr     <= n_addr;
        r_chk_idx  <= n_chk_idx;
        r_min      <= n_min;
        r_slot     <= n_slot;
        r_hit      <= n_hit;
        r_repl     <= n_repl;
        r_cnt_new  <= n_cnt_new;
        r_out_hit  <= n_out_hit;
        r_out_slot <= n_out_slot;
        r_out_repl <= n_out_repl;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_repl, r_out_slot, r_out_hit};

    // fill level never runs past the table size
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("fill level beyond table size");

    // fill level only ever steps up by one, and only from the write step of an insert
    a_fill_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |->
            ((r_fill == $past(r_fill) + FILL_W'(1)) && ($past(r_state) == S_WRITE)))
        else $error("fill level changed outside an insert");

    // a new result is only produced by the done step
    a_out_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_vld)) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside done step");

    // hit and replaced never appear together
    a_hit_repl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_hit && r_out_repl))
        else $error("result marks both hit and replaced");

endmodule
